/* design/integer_to_ascii_formatter_defines.svh */
// Assertion macros for the formatter design file.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IFA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("integer_to_ascii_formatter: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IFA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integer_to_ascii_formatter: next-cycle check failed");

`endif

/* design/ifa_pkg.sv */
// Constants and helper functions for the integer-to-ASCII formatter.
package ifa_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int WIDTH_W     = 8;
   localparam int COUNT_W     = 6;
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_MAX   = 10;
   localparam int DIGIT_IDX_W = 4;
   localparam int PROD_W      = 64;
   localparam int RECIP_SHIFT = 35;

   localparam logic [COUNT_W-1:0] MAX_FIELD = 6'd63;
   // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) equals x / 10 for every 32-bit x.
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] digit,
                                                        input logic caps);
      logic [CHAR_W-1:0] ext;
      ext = {4'b0, digit};
      if (digit < 4'd10) begin
         return CHAR_ZERO + ext;
      end
      return (caps ? CHAR_UPPER : CHAR_LOWER) + ext - 8'd10;
   endfunction

endpackage

/* design/integer_to_ascii_formatter.sv */
// Integer-to-ASCII formatter: decimal or hex conversion with sign and padding.
//
// The req_ channel takes one number with its format flags. The block turns it
// into ASCII characters, most significant first, and sends them one item per
// character on the rsp_ channel. The final item of a number has rsp_last set and
// carries the character count in rsp_total_count; earlier items carry zero there.
// Decimal digits come from a shared 32x32 reciprocal multiplier (multiply by
// 0xCCCCCCCD, shift by 35) followed by a remainder step, in states S_MUL and
// S_DIV. Hex digits are peeled off four bits at a time, one per cycle.
// A number passes through acceptance, digit generation and a sizing step, then
// the block sends one character per cycle while rsp_stall is low.
// req_stall stays high from acceptance until the last character is loaded into
// the output register, so the next number can be taken while that character
// still waits. When the receiver stalls, the output register holds its item and
// character generation pauses. Synchronous reset returns the sequencer to idle
// and empties the output register.
module integer_to_ascii_formatter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ifa_pkg::VALUE_W-1:0]    req_value,
   input  logic                           req_hex_mode,
   input  logic                           req_signed_mode,
   input  logic                           req_zero_pad,
   input  logic [ifa_pkg::WIDTH_W-1:0]    req_pad_width,
   input  logic                           req_upper_case,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ifa_pkg::CHAR_W-1:0]     rsp_character,
   output logic                           rsp_last,
   output logic [ifa_pkg::COUNT_W-1:0]    rsp_total_count
);
   import ifa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_HEX  = 3'd3;
   localparam logic [2:0] S_SIZE = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [VALUE_W-1:0]       num_ff, num_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic                     zpad_ff, zpad_in;
   logic                     caps_ff, caps_in;
   logic [COUNT_W-1:0]       width_ff, width_in;
   logic [DIGIT_IDX_W-1:0]   ndig_ff, ndig_in;
   logic [COUNT_W-1:0]       pad_ff, pad_in;
   logic [COUNT_W-1:0]       len_ff, len_in;
   logic [COUNT_W-1:0]       idx_ff, idx_in;
   logic [DIGIT_W-1:0]       digits_ff [DIGIT_MAX];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     req_take;
   logic                     out_free;
   logic                     digit_we;
   logic [DIGIT_W-1:0]       digit_wdata;
   logic [VALUE_W-1:0]       quotient;
   logic [VALUE_W-1:0]       remainder_full;
   logic [VALUE_W-1:0]       hex_next;
   logic [DIGIT_IDX_W-1:0]   body;
   logic [COUNT_W-1:0]       body_ext;
   logic [COUNT_W-1:0]       lead;
   logic [COUNT_W-1:0]       rd_pos;
   logic [CHAR_W-1:0]        cur_char;
   logic                     cur_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Reciprocal quotient and the remainder it leaves; the remainder is below ten.
   assign quotient       = {{(VALUE_W - (PROD_W - RECIP_SHIFT)){1'b0}},
                            prod_ff[PROD_W-1:RECIP_SHIFT]};
   assign remainder_full = num_ff - ((quotient << 3) + (quotient << 1));
   assign hex_next       = num_ff >> 4;

   assign body     = ndig_ff + {{(DIGIT_IDX_W-1){1'b0}}, neg_ff};
   assign body_ext = {{(COUNT_W-DIGIT_IDX_W){1'b0}}, body};
   assign lead     = pad_ff + {{(COUNT_W-1){1'b0}}, neg_ff};
   // Digits are stored least significant first, so output character idx (counted
   // over the whole field, padding included) reads entry len - 1 - idx.
   assign rd_pos   = len_ff - idx_ff - 6'd1;
   assign cur_last = (idx_ff == len_ff - 6'd1);

   always_comb begin
      if (idx_ff < lead) begin
         if (zpad_ff) begin
            cur_char = (neg_ff && idx_ff == '0) ? CHAR_MINUS : CHAR_ZERO;
         end else begin
            cur_char = (neg_ff && idx_ff == pad_ff) ? CHAR_MINUS : CHAR_SPACE;
         end
      end else begin
         cur_char = digit_to_ascii(digits_ff[rd_pos[DIGIT_IDX_W-1:0]], caps_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      zpad_in      = zpad_ff;
      caps_in      = caps_ff;
      width_in     = width_ff;
      ndig_in      = ndig_ff;
      pad_in       = pad_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      digit_we     = 1'b0;
      digit_wdata  = remainder_full[DIGIT_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               neg_in   = !req_hex_mode && req_signed_mode && req_value[VALUE_W-1];
               num_in   = neg_in ? (~req_value + 32'd1) : req_value;
               zpad_in  = req_zero_pad;
               caps_in  = req_upper_case;
               width_in = (req_pad_width > {2'b0, MAX_FIELD}) ? MAX_FIELD
                                                              : req_pad_width[COUNT_W-1:0];
               ndig_in  = '0;
               state_in = req_hex_mode ? S_HEX : S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = num_ff * RECIP_TEN;
            state_in = S_DIV;
         end
         S_DIV: begin
            digit_we    = 1'b1;
            digit_wdata = remainder_full[DIGIT_W-1:0];
            num_in      = quotient;
            ndig_in     = ndig_ff + 4'd1;
            state_in    = (quotient == '0) ? S_SIZE : S_MUL;
         end
         S_HEX: begin
            digit_we    = 1'b1;
            digit_wdata = num_ff[DIGIT_W-1:0];
            num_in      = hex_next;
            ndig_in     = ndig_ff + 4'd1;
            state_in    = (hex_next == '0) ? S_SIZE : S_HEX;
         end
         S_SIZE: begin
            pad_in   = (width_ff > body_ext) ? (width_ff - body_ext) : '0;
            len_in   = pad_in + body_ext;
            idx_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = cur_char;
               rsp_last_in  = cur_last;
               rsp_count_in = cur_last ? len_ff : '0;
               idx_in       = idx_ff + 6'd1;
               if (cur_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      zpad_ff      <= zpad_in;
      caps_ff      <= caps_in;
      width_ff     <= width_in;
      pad_ff       <= pad_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         digits_ff[ndig_ff] <= digit_wdata;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = rsp_char_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_total_count = rsp_count_ff;

`include "integer_to_ascii_formatter_defines.svh"

   // An accepted number always starts the sequencer.
   `IFA_ASSERT_NEXT(a_take_starts, req_valid && !req_stall, state_ff != S_IDLE)
   // Only the final character of a number carries a nonzero count.
   `IFA_ASSERT_NOW(a_count_on_last, rsp_valid && (rsp_total_count != '0), rsp_last)
   `IFA_ASSERT_NOW(a_last_has_count, rsp_valid && rsp_last, rsp_total_count != '0)
   // A 32-bit value never needs more than ten digits.
   `IFA_ASSERT_NOW(a_digit_bound, state_ff != S_IDLE, ndig_ff <= 4'd10)

endmodule
